/* sv/fwtm_pkg.sv */
package fwtm_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_BIAS      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SCALE     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_BIAS     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SCALE    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_THRESHOLD = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING_GAIN   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_GAIN      = 4'd7;

  localparam logic [11:0] RST_LEFT_BIAS      = 12'd2048;
  localparam logic [15:0] RST_LEFT_SCALE     = 16'd8192;
  localparam logic [11:0] RST_RIGHT_BIAS     = 12'd2048;
  localparam logic [15:0] RST_RIGHT_SCALE    = 16'd8192;
  localparam logic [15:0] RST_MODE_THRESHOLD = 16'd8192;
  localparam logic [15:0] RST_FILTER_COEFF   = 16'd6554;
  localparam logic [23:0] RST_DAMPING_GAIN   = 24'd336;
  localparam logic [15:0] RST_LOCK_GAIN      = 16'd25736;

  // Split weights, Q0.16
  localparam logic [16:0] COEF_REAR_DRIFT  = 17'd52429;
  localparam logic [16:0] COEF_FRONT_DRIFT = 17'd13107;
  localparam logic [16:0] COEF_HALF        = 17'd32768;
  localparam logic [16:0] Q16_ONE          = 17'h10000;

  // Shared multiply-accumulate widths
  localparam int A_W   = 27;
  localparam int B_W   = 25;
  localparam int P_W   = A_W + B_W;
  localparam int ACC_W = P_W + 1;
  localparam int RES_W = 29;

  typedef logic [1:0] shift_sel_t;
  localparam shift_sel_t SH_12 = 2'd0;
  localparam shift_sel_t SH_14 = 2'd1;
  localparam shift_sel_t SH_16 = 2'd2;
  localparam shift_sel_t SH_26 = 2'd3;

  typedef struct packed {
    logic       en;
    logic       start;
    shift_sel_t shift;
  } mac_ctl_t;

  typedef struct packed {
    logic [11:0]        left_sample;
    logic [11:0]        right_sample;
    logic [15:0]        mode_sample;
    logic signed [23:0] speed_front_right;
    logic signed [23:0] speed_front_left;
    logic signed [23:0] speed_back_right;
    logic signed [23:0] speed_back_left;
    logic               ready_front_right;
    logic               ready_front_left;
    logic               ready_back_right;
    logic               ready_back_left;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] drive_front_right;
    logic signed [23:0] drive_front_left;
    logic signed [23:0] drive_back_right;
    logic signed [23:0] drive_back_left;
    logic signed [23:0] total_demand;
    logic               drift_active;
    logic               enable;
  } out_word_t;

  typedef struct packed {
    logic [11:0] left_bias;
    logic [15:0] left_scale;
    logic [11:0] right_bias;
    logic [15:0] right_scale;
    logic [15:0] mode_threshold;
    logic [15:0] filter_coeff;
    logic [23:0] damping_gain;
    logic [15:0] lock_gain;
  } cfg_t;

endpackage

/* sv/fwtm_in_if.sv */
interface fwtm_in_if;
  logic                valid;
  logic                ready;
  fwtm_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/fwtm_out_if.sv */
interface fwtm_out_if;
  logic                valid;
  logic                ready;
  fwtm_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/fwtm_cfg_if.sv */
interface fwtm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fwtm_pkg::CFG_IDX_W-1:0]  index;
  logic [fwtm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/fwtm_regs.sv */
module fwtm_regs (
  input  logic           clk,
  input  logic           rst_n,
  fwtm_cfg_if.sink       cfg_ch,
  output fwtm_pkg::cfg_t cfg
);

  fwtm_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_bias      <= fwtm_pkg::RST_LEFT_BIAS;
      cfg_r.left_scale     <= fwtm_pkg::RST_LEFT_SCALE;
      cfg_r.right_bias     <= fwtm_pkg::RST_RIGHT_BIAS;
      cfg_r.right_scale    <= fwtm_pkg::RST_RIGHT_SCALE;
      cfg_r.mode_threshold <= fwtm_pkg::RST_MODE_THRESHOLD;
      cfg_r.filter_coeff   <= fwtm_pkg::RST_FILTER_COEFF;
      cfg_r.damping_gain   <= fwtm_pkg::RST_DAMPING_GAIN;
      cfg_r.lock_gain      <= fwtm_pkg::RST_LOCK_GAIN;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        fwtm_pkg::CFG_LEFT_BIAS:      cfg_r.left_bias      <= cfg_ch.data[11:0];
        fwtm_pkg::CFG_LEFT_SCALE:     cfg_r.left_scale     <= cfg_ch.data[15:0];
        fwtm_pkg::CFG_RIGHT_BIAS:     cfg_r.right_bias     <= cfg_ch.data[11:0];
        fwtm_pkg::CFG_RIGHT_SCALE:    cfg_r.right_scale    <= cfg_ch.data[15:0];
        fwtm_pkg::CFG_MODE_THRESHOLD: cfg_r.mode_threshold <= cfg_ch.data[15:0];
        fwtm_pkg::CFG_FILTER_COEFF:   cfg_r.filter_coeff   <= cfg_ch.data[15:0];
        fwtm_pkg::CFG_DAMPING_GAIN:   cfg_r.damping_gain   <= cfg_ch.data[23:0];
        fwtm_pkg::CFG_LOCK_GAIN:      cfg_r.lock_gain      <= cfg_ch.data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/fwtm_mac.sv */
module fwtm_mac (
  input  logic                                clk,
  input  fwtm_pkg::mac_ctl_t                  ctl,
  input  logic signed [fwtm_pkg::A_W-1:0]     op_a,
  input  logic signed [fwtm_pkg::B_W-1:0]     op_b,
  output logic signed [fwtm_pkg::RES_W-1:0]   res
);

  logic signed [fwtm_pkg::P_W-1:0]   prod;
  logic signed [fwtm_pkg::ACC_W-1:0] acc_r;
  logic signed [fwtm_pkg::ACC_W-1:0] acc_nxt;
  logic signed [fwtm_pkg::ACC_W-1:0] half;
  logic signed [fwtm_pkg::ACC_W-1:0] shifted;

  assign prod = op_a * op_b;

  // Rounding bias for round-half-up, loaded at the start of a group
  always_comb begin
    unique case (ctl.shift)
      fwtm_pkg::SH_12: half = fwtm_pkg::ACC_W'(2048);
      fwtm_pkg::SH_14: half = fwtm_pkg::ACC_W'(8192);
      fwtm_pkg::SH_16: half = fwtm_pkg::ACC_W'(32768);
      fwtm_pkg::SH_26: half = fwtm_pkg::ACC_W'(33554432);
    endcase
  end

  assign acc_nxt = (ctl.start ? half : acc_r)
                 + {{(fwtm_pkg::ACC_W - fwtm_pkg::P_W){prod[fwtm_pkg::P_W-1]}}, prod};

  always_comb begin
    unique case (ctl.shift)
      fwtm_pkg::SH_12: shifted = acc_nxt >>> 12;
      fwtm_pkg::SH_14: shifted = acc_nxt >>> 14;
      fwtm_pkg::SH_16: shifted = acc_nxt >>> 16;
      fwtm_pkg::SH_26: shifted = acc_nxt >>> 26;
    endcase
  end

  assign res = shifted[fwtm_pkg::RES_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

/* sv/fwtm_core.sv */
module fwtm_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  fwtm_pkg::in_word_t                in_word,
  input  fwtm_pkg::cfg_t                    cfg,
  input  logic                              out_free,
  output logic                              busy,
  output logic                              done,
  output fwtm_pkg::out_word_t               result,
  output fwtm_pkg::mac_ctl_t                mac_ctl,
  output logic signed [fwtm_pkg::A_W-1:0]   op_a,
  output logic signed [fwtm_pkg::B_W-1:0]   op_b,
  input  logic signed [fwtm_pkg::RES_W-1:0] res
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  localparam logic [4:0] STEP_LX         = 5'd0;
  localparam logic [4:0] STEP_RX         = 5'd1;
  localparam logic [4:0] STEP_LF_OLD     = 5'd2;
  localparam logic [4:0] STEP_LF_NEW     = 5'd3;
  localparam logic [4:0] STEP_RF_OLD     = 5'd4;
  localparam logic [4:0] STEP_RF_NEW     = 5'd5;
  localparam logic [4:0] STEP_MF_OLD     = 5'd6;
  localparam logic [4:0] STEP_MF_NEW     = 5'd7;
  localparam logic [4:0] STEP_DAMP       = 5'd8;
  localparam logic [4:0] STEP_TOTAL      = 5'd9;
  localparam logic [4:0] STEP_REAR       = 5'd10;
  localparam logic [4:0] STEP_FRONT      = 5'd11;
  localparam logic [4:0] STEP_TERM_FR    = 5'd12;
  localparam logic [4:0] STEP_TERM_FL    = 5'd13;
  localparam logic [4:0] STEP_TERM_BR    = 5'd14;
  localparam logic [4:0] STEP_TERM_BL    = 5'd15;
  localparam logic [4:0] STEP_LAST_WHEEL = 5'd16;
  localparam logic [4:0] STEP_DONE       = 5'd17;

  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    if (v > 30'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -30'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  logic                      state_r, state_nxt;
  logic [4:0]                step_r, step_nxt;
  fwtm_pkg::in_word_t        word_r;
  logic signed [24:0]        sf_r, sb_r;
  logic signed [25:0]        s_r;
  logic signed [24:0]        sf_in, sb_in;
  logic signed [16:0]        lx_r, rx_r;
  logic signed [23:0]        lf_r, rf_r, mf_r;
  logic signed [23:0]        d_r, total_r, rear_r, front_r;
  logic                      drift_r;
  logic signed [28:0]        term_r;
  logic signed [23:0]        wheel_r [4];

  logic signed [12:0]        l_diff, r_diff;
  logic [16:0]               omc;
  logic [1:0]                term_idx, wheel_idx;
  logic signed [23:0]        term_speed;
  logic signed [24:0]        term_axle;
  logic signed [26:0]        speed4, axle2, s27, lock_d;
  logic signed [27:0]        demand_diff;
  logic signed [29:0]        wheel_sum;
  logic signed [23:0]        wheel_split;
  logic                      drift_hit;
  logic                      wheel_wr;

  // Axle sums at capture
  assign sf_in = {in_word.speed_front_right[23], in_word.speed_front_right}
               + {in_word.speed_front_left[23], in_word.speed_front_left};
  assign sb_in = {in_word.speed_back_right[23], in_word.speed_back_right}
               + {in_word.speed_back_left[23], in_word.speed_back_left};

  assign l_diff = $signed({1'b0, word_r.left_sample}) - $signed({1'b0, cfg.left_bias});
  assign r_diff = $signed({1'b0, word_r.right_sample}) - $signed({1'b0, cfg.right_bias});
  assign omc    = fwtm_pkg::Q16_ONE - {1'b0, cfg.filter_coeff};

  // Lock term operand for the wheel under work
  assign term_idx = step_r[1:0];
  always_comb begin
    unique case (term_idx)
      2'd0: term_speed = word_r.speed_front_right;
      2'd1: term_speed = word_r.speed_front_left;
      2'd2: term_speed = word_r.speed_back_right;
      2'd3: term_speed = word_r.speed_back_left;
    endcase
  end
  assign term_axle = term_idx[1] ? sb_r : sf_r;
  assign speed4    = {term_speed[23], term_speed, 2'b00};
  assign axle2     = {term_axle[24], term_axle, 1'b0};
  assign s27       = {s_r[25], s_r};
  assign lock_d    = drift_r ? (axle2 - speed4) : (s27 - speed4);

  assign demand_diff = {{4{rf_r[23]}}, rf_r} - {{4{lf_r[23]}}, lf_r} - {{4{d_r[23]}}, d_r};
  assign drift_hit   = mf_r > $signed({8'b0, cfg.mode_threshold});

  // Wheel finish trails the lock term by one step
  assign wheel_idx   = step_r[1:0] - 2'd1;
  assign wheel_split = wheel_idx[1] ? rear_r : front_r;
  assign wheel_sum   = {{6{wheel_split[23]}}, wheel_split} + {term_r[28], term_r};
  assign wheel_wr    = (state_r == S_RUN) && (step_r >= STEP_TERM_FL)
                    && (step_r <= STEP_LAST_WHEEL);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    done      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RUN;
          step_nxt  = STEP_LX;
        end
      end
      S_RUN: begin
        if (step_r == STEP_DONE) begin
          if (out_free) begin
            done      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
    endcase
  end

  assign busy = (state_r == S_RUN);

  // Operand selection for the shared unit
  always_comb begin
    mac_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    if (state_r == S_RUN) begin
      unique case (step_r)
        STEP_LX: begin
          mac_ctl = '{en: 1'b1, start: 1'b1, shift: fwtm_pkg::SH_12};
          op_a    = {{14{l_diff[12]}}, l_diff};
          op_b    = {9'b0, cfg.left_scale};
        end
        STEP_RX: begin
          mac_ctl = '{en: 1'b1, start: 1'b1, shift: fwtm_pkg::SH_12};
          op_a    = {{14{r_diff[12]}}, r_diff};
          op_b    = {9'b0, cfg.right_scale};
        end
        STEP_LF_OLD: begin
          mac_ctl = '{en: 1'b1, start: 1'b1, shift: fwtm_pkg::SH_16};
          op_a    = {{3{lf_r[23]}}, lf_r};
          op_b    = {8'b0, omc};
        end
        STEP_LF_NEW: begin
          mac_ctl = '{en: 1'b1, start: 1'b0, shift: fwtm_pkg::SH_16};
          op_a    = {{10{lx_r[16]}}, lx_r};
          op_b    = {9'b0, cfg.filter_coeff};
        end
        STEP_RF_OLD: begin
          mac_ctl = '{en: 1'b1, start: 1'b1, shift: fwtm_pkg::SH_16};
          op_a    = {{3{rf_r[23]}}, rf_r};
          op_b    = {8'b0, omc};
        end
        STEP_RF_NEW: begin
          mac_ctl = '{en: 1'b1, start: 1'b0, shift: fwtm_pkg::SH_16};
          op_a    = {{10{rx_r[16]}}, rx_r};
          op_b    = {9'b0, cfg.filter_coeff};
        end
        STEP_MF_OLD: begin
          mac_ctl = '{en: 1'b1, start: 1'b1, shift: fwtm_pkg::SH_16};
          op_a    = {{3{mf_r[23]}}, mf_r};
          op_b    = {8'b0, omc};
        end
        STEP_MF_NEW: begin
          mac_ctl = '{en: 1'b1, start: 1'b0, shift: fwtm_pkg::SH_16};
          op_a    = {11'b0, word_r.mode_sample};
          op_b    = {9'b0, cfg.filter_coeff};
        end
        STEP_DAMP: begin
          mac_ctl = '{en: 1'b1, start: 1'b1, shift: fwtm_pkg::SH_26};
          op_a    = {s_r[25], s_r};
          op_b    = {1'b0, cfg.damping_gain};
        end
        STEP_REAR: begin
          mac_ctl = '{en: 1'b1, start: 1'b1, shift: fwtm_pkg::SH_16};
          op_a    = {{3{total_r[23]}}, total_r};
          op_b    = {8'b0, (drift_r ? fwtm_pkg::COEF_REAR_DRIFT : fwtm_pkg::COEF_HALF)};
        end
        STEP_FRONT: begin
          mac_ctl = '{en: 1'b1, start: 1'b1, shift: fwtm_pkg::SH_16};
          op_a    = {{3{total_r[23]}}, total_r};
          op_b    = {8'b0, (drift_r ? fwtm_pkg::COEF_FRONT_DRIFT : fwtm_pkg::COEF_HALF)};
        end
        STEP_TERM_FR, STEP_TERM_FL, STEP_TERM_BR, STEP_TERM_BL: begin
          mac_ctl = '{en: 1'b1, start: 1'b1, shift: fwtm_pkg::SH_14};
          op_a    = lock_d;
          op_b    = {9'b0, cfg.lock_gain};
        end
        default: begin
        end
      endcase
    end
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= STEP_LX;
      lf_r    <= '0;
      rf_r    <= '0;
      mf_r    <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (state_r == S_RUN) begin
        if (step_r == STEP_LF_NEW) lf_r <= res[23:0];
        if (step_r == STEP_RF_NEW) rf_r <= res[23:0];
        if (step_r == STEP_MF_NEW) mf_r <= res[23:0];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      word_r <= in_word;
      sf_r   <= sf_in;
      sb_r   <= sb_in;
      s_r    <= {sf_in[24], sf_in} + {sb_in[24], sb_in};
    end
    if (state_r == S_RUN) begin
      unique case (step_r)
        STEP_LX:    lx_r <= res[16:0];
        STEP_RX:    rx_r <= res[16:0];
        STEP_DAMP:  d_r  <= res[23:0];
        STEP_TOTAL: begin
          total_r <= sat24({{2{demand_diff[27]}}, demand_diff} <<< 1);
          drift_r <= drift_hit;
        end
        STEP_REAR:  rear_r  <= res[23:0];
        STEP_FRONT: front_r <= res[23:0];
        STEP_TERM_FR, STEP_TERM_FL, STEP_TERM_BR, STEP_TERM_BL: term_r <= res;
        default: begin
        end
      endcase
    end
    if (wheel_wr) begin
      wheel_r[wheel_idx] <= sat24(wheel_sum);
    end
  end

  assign result.drive_front_right = wheel_r[0];
  assign result.drive_front_left  = wheel_r[1];
  assign result.drive_back_right  = wheel_r[2];
  assign result.drive_back_left   = wheel_r[3];
  assign result.total_demand      = total_r;
  assign result.drift_active      = drift_r;
  assign result.enable            = word_r.ready_front_right & word_r.ready_front_left
                                  & word_r.ready_back_right & word_r.ready_back_left;

endmodule

/* sv/four_wheel_torque_mixer.sv */
// Four-wheel torque mixer: one control tick per input word.
// in_ch  : sensor word (left/right/mode samples, four wheel speeds, four
//          drive-ready flags), valid/ready, accepted when both are high.
// out_ch : result word (four saturated wheel torques, total demand, drift
//          flag, enable), valid/ready with a registered output word.
// cfg_ch : register write channel (index, data), always ready; write only
//          while the block is idle.
// All multiplies of a tick go through one shared 27x25 multiply-accumulate
// unit, 15 products in sequence, plus one add step for the total demand,
// one for the last wheel and one hand-off step into the output register;
// the input reopens the cycle after that, so a new word is never taken
// before the previous tick is through.
// in_ch.ready is low while a tick is being worked. A new word is taken while
// the previous result still waits on out_ch; a finished tick then holds in
// its last step until the output register is free, so a stalled receiver
// loses nothing and only delays the next word.
// Reset (rst_n low, synchronous) clears the three filter states to zero,
// loads the register defaults, and drops out_ch.valid.
module four_wheel_torque_mixer (
  input  logic       clk,
  input  logic       rst_n,
  fwtm_in_if.sink    in_ch,
  fwtm_out_if.source out_ch,
  fwtm_cfg_if.sink   cfg_ch
);

  fwtm_pkg::cfg_t                    cfg;
  fwtm_pkg::mac_ctl_t                mac_ctl;
  fwtm_pkg::out_word_t               core_result;
  fwtm_pkg::out_word_t               out_word_r;
  logic signed [fwtm_pkg::A_W-1:0]   op_a;
  logic signed [fwtm_pkg::B_W-1:0]   op_b;
  logic signed [fwtm_pkg::RES_W-1:0] mac_res;
  logic                              core_busy;
  logic                              core_done;
  logic                              out_free;
  logic                              in_accept;
  logic                              out_valid_r, out_valid_nxt;

  // Register file
  fwtm_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Shared multiply-accumulate with round-half-up shift
  fwtm_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .res  (mac_res)
  );

  // Sequencer and working registers
  fwtm_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .in_word  (in_ch.data),
    .cfg      (cfg),
    .out_free (out_free),
    .busy     (core_busy),
    .done     (core_done),
    .result   (core_result),
    .mac_ctl  (mac_ctl),
    .op_a     (op_a),
    .op_b     (op_b),
    .res      (mac_res)
  );

  // Take a word only when no tick is in flight
  assign in_ch.ready = !core_busy;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // Output slot is free when empty or drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (core_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the finished word; hold it while the receiver stalls
  always_ff @(posedge clk) begin
    if (core_done) begin
      out_word_r <= core_result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // A word taken starts a tick, so the input closes on the next cycle
  a_accept_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ch.ready)
    else $error("input stayed open after a word was taken");

  // A tick only finishes into a free output slot
  a_done_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> out_free)
    else $error("tick finished while output word still pending");

  // A finished tick shows up on the output next cycle
  a_done_shows_output: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |=> out_ch.valid)
    else $error("finished tick did not reach the output");

  // Output valid only rises at the end of a tick
  a_valid_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(core_busy))
    else $error("output valid rose without a tick in flight");

endmodule
